// File: sv/bounded_array_list_unit_assert.svh
// Assertion helpers for the list unit. Both sample on clk_i and are off during reset.
`ifndef BOUNDED_ARRAY_LIST_UNIT_ASSERT_SVH
`define BOUNDED_ARRAY_LIST_UNIT_ASSERT_SVH

// Same-cycle implication.
`define BAL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BAL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/bal_pkg.sv
package bal_pkg;

  localparam int unsigned DEPTH_DEF = 16;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned FIDX_W = 4;
  localparam int unsigned CNT_W  = 5;

  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ERASE      = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FIND       = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] STAT_BADPOS   = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd4;

endpackage

// File: sv/bounded_array_list_unit.sv
// Channel | Handshake                | Payload
// --------+--------------------------+-----------------------------------
// in      | in_valid_i, in_stall_o   | command_i, position_i, value_i
// out     | out_valid_o, out_stall_i | status_o, found_index_o, count_o
//
// One command at a time. Push back, pop back, appends and rejected commands go
// straight to done. Insert / push front shifts the tail up, top entry first, then
// writes the value; erase shifts the tail down; find scans up to the first match.
// Each moved or searched entry uses the single read / single write port of the element
// memory. Reset clears count, state and output valid; the memory needs no clearing
// pass. A stalled result holds the unit in its done state with in_stall_o high.
module bounded_array_list_unit #(
  parameter int unsigned DEPTH = bal_pkg::DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [bal_pkg::CMD_W-1:0]  command_i,
  input  logic [bal_pkg::POS_W-1:0]  position_i,
  input  logic signed [bal_pkg::VAL_W-1:0] value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [bal_pkg::STAT_W-1:0] status_o,
  output logic [bal_pkg::FIDX_W-1:0] found_index_o,
  output logic [bal_pkg::CNT_W-1:0]  count_o
);
  import bal_pkg::*;

  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CW > POS_W) ? CW : POS_W;

  localparam int unsigned SW = 3;
  localparam logic [SW-1:0] S_IDLE = 3'd0;
  localparam logic [SW-1:0] S_UP   = 3'd1;
  localparam logic [SW-1:0] S_PUT  = 3'd2;
  localparam logic [SW-1:0] S_DN   = 3'd3;
  localparam logic [SW-1:0] S_FIND = 3'd4;
  localparam logic [SW-1:0] S_DONE = 3'd5;

  logic [SW-1:0]     state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [AW-1:0]     at_q, at_d;
  logic [VAL_W-1:0]  val_q, val_d;
  logic [STAT_W-1:0] stat_q, stat_d;
  logic [AW-1:0]     found_q, found_d;

  logic              out_valid_q, out_valid_d;
  logic [STAT_W-1:0] out_stat_q;
  logic [FIDX_W-1:0] out_fidx_q;
  logic [CNT_W-1:0]  out_cnt_q;

  logic [VAL_W-1:0]  mem_q [DEPTH];
  logic [VAL_W-1:0]  rd_q;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [AW-1:0]     mem_ra;
  logic [VAL_W-1:0]  mem_wd;

  logic              out_free;
  logic              is_full;
  logic              is_empty;
  logic [CW-1:0]     cnt_m1;
  logic [CMP_W-1:0]  pos_x;
  logic [CMP_W-1:0]  cnt_x;
  logic [CMP_W-1:0]  ins_at;

  assign out_free = !out_valid_q || !out_stall_i;
  assign is_full  = (cnt_q == CW'(DEPTH));
  assign is_empty = (cnt_q == '0);
  assign cnt_m1   = cnt_q - CW'(1);
  assign pos_x    = CMP_W'(position_i);
  assign cnt_x    = CMP_W'(cnt_q);
  assign ins_at   = (command_i == CMD_PUSH_FRONT) ? '0 :
                    ((pos_x < cnt_x) ? pos_x : cnt_x);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    at_d    = at_q;
    val_d   = val_q;
    stat_d  = stat_q;
    found_d = found_q;
    mem_we  = 1'b0;
    mem_wa  = idx_q;
    mem_wd  = rd_q;
    mem_ra  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          val_d   = value_i;
          stat_d  = STAT_OK;
          found_d = '0;
          state_d = S_DONE;
          unique case (command_i)
            CMD_PUSH_BACK: begin
              if (is_full) begin
                stat_d = STAT_FULL;
              end else begin
                mem_we = 1'b1;
                mem_wa = cnt_q[AW-1:0];
                mem_wd = value_i;
                cnt_d  = cnt_q + CW'(1);
              end
            end
            CMD_PUSH_FRONT, CMD_INSERT: begin
              if (is_full) begin
                stat_d = STAT_FULL;
              end else if (ins_at == cnt_x) begin
                mem_we = 1'b1;
                mem_wa = cnt_q[AW-1:0];
                mem_wd = value_i;
                cnt_d  = cnt_q + CW'(1);
              end else begin
                // shift the tail up one slot, top entry first
                at_d    = ins_at[AW-1:0];
                idx_d   = cnt_q[AW-1:0];
                mem_ra  = cnt_m1[AW-1:0];
                state_d = S_UP;
              end
            end
            CMD_POP_BACK: begin
              if (is_empty) stat_d = STAT_EMPTY;
              else cnt_d = cnt_m1;
            end
            CMD_ERASE: begin
              if (is_empty) begin
                stat_d = STAT_EMPTY;
              end else if (pos_x >= cnt_x) begin
                stat_d = STAT_BADPOS;
              end else if (pos_x == CMP_W'(cnt_m1)) begin
                cnt_d = cnt_m1;
              end else begin
                idx_d   = pos_x[AW-1:0];
                mem_ra  = pos_x[AW-1:0] + AW'(1);
                state_d = S_DN;
              end
            end
            CMD_FIND: begin
              stat_d = STAT_NOTFOUND;
              if (!is_empty) begin
                idx_d   = '0;
                mem_ra  = '0;
                state_d = S_FIND;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_UP: begin
        // rd_q holds entry idx-1, read last cycle
        mem_we = 1'b1;
        mem_wa = idx_q;
        mem_wd = rd_q;
        if ((idx_q - AW'(1)) == at_q) begin
          state_d = S_PUT;
        end else begin
          mem_ra = idx_q - AW'(2);
          idx_d  = idx_q - AW'(1);
        end
      end
      S_PUT: begin
        mem_we  = 1'b1;
        mem_wa  = at_q;
        mem_wd  = val_q;
        cnt_d   = cnt_q + CW'(1);
        state_d = S_DONE;
      end
      S_DN: begin
        // rd_q holds entry idx+1
        mem_we = 1'b1;
        mem_wa = idx_q;
        mem_wd = rd_q;
        if ((CW'(idx_q) + CW'(2)) == cnt_q) begin
          cnt_d   = cnt_m1;
          state_d = S_DONE;
        end else begin
          mem_ra = idx_q + AW'(2);
          idx_d  = idx_q + AW'(1);
        end
      end
      S_FIND: begin
        if (rd_q == val_q) begin
          stat_d  = STAT_OK;
          found_d = idx_q;
          state_d = S_DONE;
        end else if ((CW'(idx_q) + CW'(1)) == cnt_q) begin
          state_d = S_DONE;
        end else begin
          mem_ra = idx_q + AW'(1);
          idx_d  = idx_q + AW'(1);
        end
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = ((state_q == S_DONE) && out_free) || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    at_q    <= at_d;
    val_q   <= val_d;
    stat_q  <= stat_d;
    found_q <= found_d;
    if ((state_q == S_DONE) && out_free) begin
      out_stat_q <= stat_q;
      out_fidx_q <= FIDX_W'(found_q);
      out_cnt_q  <= CNT_W'(cnt_q);
    end
  end

  // element store: one write port, one read port, registered read data
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rd_q <= mem_q[mem_ra];
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_stat_q;
  assign found_index_o = out_fidx_q;
  assign count_o       = out_cnt_q;

`include "bounded_array_list_unit_assert.svh"

  `BAL_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CW'(DEPTH), "count above capacity")
  `BAL_ASSERT_IMP(a_cnt_step, 1'b1,
                  (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + CW'(1)) ||
                  (cnt_q == $past(cnt_q) - CW'(1)), "count moved by more than one")
  `BAL_ASSERT_NXT(a_find_keeps_cnt, state_q == S_FIND, cnt_q == $past(cnt_q), "find changed count")
  `BAL_ASSERT_IMP(a_up_not_full, state_q == S_UP, !is_full, "shift up on full list")
  `BAL_ASSERT_NXT(a_done_loads, (state_q == S_DONE) && out_free, out_valid_q, "result transfer lost")

endmodule

// File: tb/sv/tb_bounded_array_list_unit.sv
`timescale 1ns / 1ps

module tb_bounded_array_list_unit;
  import bal_pkg::*;

  localparam int unsigned LIST_DEPTH  = DEPTH_DEF;
  // commands 6 and 7 are reserved; the unit answers them without touching the list
  localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd7;
  localparam int RANDOM_BLOCKS = 34;
  localparam int BLOCK_ITEMS   = 50;
  localparam int QUIET_TAIL    = 150;  // last commands run with no idling on either side
  localparam int HOLD_START    = 4000;
  localparam int HOLD_LEN      = 600;
  localparam int SETTLE_CYCLES = 4 * LIST_DEPTH + 8;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_SEARCH} traffic_mix_e;

  typedef struct {
    logic [CMD_W-1:0]        command;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
    bit                      wait_idle;  // hold this command until all results are back
  } list_cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [FIDX_W-1:0] found_index;
    logic [CNT_W-1:0]  count;
  } list_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [CMD_W-1:0]         command_i = CMD_PUSH_BACK;
  logic [POS_W-1:0]         position_i = '0;
  logic signed [VAL_W-1:0]  value_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [STAT_W-1:0]        status_o;
  logic [FIDX_W-1:0]        found_index_o;
  logic [CNT_W-1:0]         count_o;

  list_cmd_t               pending_q[$];
  list_result_t            list_results_q[$];
  list_cmd_t               offered_cmd;
  logic signed [VAL_W-1:0] list_store[LIST_DEPTH];
  int                      list_len;
  logic signed [VAL_W-1:0] value_pool[8];
  int                      send_gap;
  int                      recv_gap;
  int                      items_sent;
  int                      results_seen;
  int                      mismatches;
  int                      run_cycles;
  logic                    hold_off;

  bounded_array_list_unit #(
    .DEPTH(LIST_DEPTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .found_index_o(found_index_o),
    .count_o      (count_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // list behavior: updates the shadow store and returns the answer for one command
  function automatic list_result_t apply_list_command(list_cmd_t c);
    list_result_t r;
    int           at;
    bit           hit;
    r   = '0;
    hit = 1'b0;
    case (c.command)
      CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_INSERT: begin
        if (list_len >= LIST_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          if (c.command == CMD_PUSH_BACK) at = list_len;
          else if (c.command == CMD_PUSH_FRONT) at = 0;
          else at = (int'(c.position) < list_len) ? int'(c.position) : list_len;
          for (int i = list_len; i > at; i--) list_store[i] = list_store[i-1];
          list_store[at] = c.value;
          list_len++;
        end
      end
      CMD_POP_BACK: begin
        if (list_len == 0) r.status = STAT_EMPTY;
        else list_len--;
      end
      CMD_ERASE: begin
        if (list_len == 0) begin
          r.status = STAT_EMPTY;
        end else if (int'(c.position) >= list_len) begin
          r.status = STAT_BADPOS;
        end else begin
          for (int i = c.position; i + 1 < list_len; i++) list_store[i] = list_store[i+1];
          list_len--;
        end
      end
      CMD_FIND: begin
        r.status = STAT_NOTFOUND;
        for (int i = 0; i < list_len; i++) begin
          if (!hit && list_store[i] == c.value) begin
            hit           = 1'b1;
            r.status      = STAT_OK;
            r.found_index = FIDX_W'(i);
          end
        end
      end
      default: ;
    endcase
    r.count = CNT_W'(list_len);
    return r;
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(traffic_mix_e mix);
    int unsigned roll;
    int unsigned push_lim, find_lim, erase_lim, pop_lim;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:   begin push_lim = 65; find_lim = 78; erase_lim = 88; pop_lim = 98; end
      MIX_DRAIN:  begin push_lim = 20; find_lim = 35; erase_lim = 65; pop_lim = 98; end
      MIX_SEARCH: begin push_lim = 30; find_lim = 80; erase_lim = 90; pop_lim = 98; end
      default:    begin push_lim = 40; find_lim = 60; erase_lim = 78; pop_lim = 98; end
    endcase
    if (roll < push_lim) begin
      case ($urandom_range(0, 2))
        0:       return CMD_PUSH_BACK;
        1:       return CMD_PUSH_FRONT;
        default: return CMD_INSERT;
      endcase
    end
    if (roll < find_lim) return CMD_FIND;
    if (roll < erase_lim) return CMD_ERASE;
    if (roll < pop_lim) return CMD_POP_BACK;
    return $urandom_range(0, 1) ? CMD_RSVD_A : CMD_RSVD_B;
  endfunction

  task automatic queue_cmd(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                           logic signed [VAL_W-1:0] val, bit wait_idle);
    list_cmd_t c;
    c.command   = cmd;
    c.position  = pos;
    c.value     = val;
    c.wait_idle = wait_idle;
    pending_q.push_back(c);
  endtask

  task automatic flag_mismatch(string what, list_result_t exp_r, list_result_t got_r);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected status %0d index %0d count %0d, got status %0d index %0d count %0d",
               $realtime, what, exp_r.status, exp_r.found_index, exp_r.count,
               got_r.status, got_r.found_index, got_r.count);
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      command_i  <= CMD_PUSH_BACK;
      position_i <= '0;
      value_i    <= '0;
      send_gap   = 0;
      items_sent = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        list_results_q.push_back(apply_list_command(offered_cmd));
        items_sent++;
        if (pending_q.size() > QUIET_TAIL && (items_sent / 128) % 3 != 0 &&
            $urandom_range(0, 5) == 0)
          send_gap = $urandom_range(1, 17);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0 &&
                     !(pending_q[0].wait_idle && list_results_q.size() > 0)) begin
          offered_cmd = pending_q.pop_front();
          in_valid_i <= 1'b1;
          command_i  <= offered_cmd.command;
          position_i <= offered_cmd.position;
          value_i    <= offered_cmd.value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long output hold-off so the unit backs up and stalls its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_cycles <= 0;
      hold_off   <= 1'b0;
    end else begin
      run_cycles <= run_cycles + 1;
      hold_off   <= (run_cycles >= HOLD_START) && (run_cycles < HOLD_START + HOLD_LEN);
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t got_r;
    list_result_t exp_r;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_gap     = 0;
      results_seen = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got_r.status      = status_o;
        got_r.found_index = found_index_o;
        got_r.count       = count_o;
        results_seen++;
        if (list_results_q.size() == 0) begin
          flag_mismatch("result with nothing outstanding", '0, got_r);
        end else begin
          exp_r = list_results_q.pop_front();
          if (got_r.status !== exp_r.status || got_r.found_index !== exp_r.found_index ||
              got_r.count !== exp_r.count)
            flag_mismatch("result mismatch", exp_r, got_r);
        end
        if (pending_q.size() > QUIET_TAIL && (results_seen / 100) % 3 != 1 &&
            $urandom_range(0, 4) == 0)
          recv_gap = $urandom_range(1, 17);
      end
      out_stall_i <= hold_off || (recv_gap > 0);
      if (recv_gap > 0) recv_gap--;
    end
  end

  initial begin
    traffic_mix_e mix;
    logic signed [VAL_W-1:0] v;
    mismatches    = 0;
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7FFF_FFFF;
    value_pool[2] = '0;
    value_pool[3] = -32'sd1;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom;

    // empty-list cases, extremes, append past the end, first-match find
    queue_cmd(CMD_FIND,       4'd0,  32'sd0,         1'b0);
    queue_cmd(CMD_POP_BACK,   4'd0,  32'sd0,         1'b0);
    queue_cmd(CMD_ERASE,      4'd0,  32'sd0,         1'b0);
    queue_cmd(CMD_PUSH_BACK,  4'd0,  32'sh8000_0000, 1'b0);
    queue_cmd(CMD_PUSH_FRONT, 4'd15, 32'sh7FFF_FFFF, 1'b0);
    queue_cmd(CMD_INSERT,     4'd15, -32'sd1,        1'b0);
    queue_cmd(CMD_INSERT,     4'd0,  32'sd0,         1'b0);
    queue_cmd(CMD_INSERT,     4'd2,  32'sh5555_AAAA, 1'b0);
    queue_cmd(CMD_FIND,       4'd7,  32'sh7FFF_FFFF, 1'b0);
    queue_cmd(CMD_FIND,       4'd0,  32'sh1234_5678, 1'b0);
    queue_cmd(CMD_ERASE,      4'd15, 32'sd0,         1'b0);
    queue_cmd(CMD_ERASE,      4'd4,  32'sd0,         1'b0);
    queue_cmd(CMD_ERASE,      4'd0,  32'sd0,         1'b0);
    queue_cmd(CMD_POP_BACK,   4'd9,  32'sd0,         1'b0);
    queue_cmd(CMD_RSVD_A,     4'd15, -32'sd1,        1'b0);
    queue_cmd(CMD_RSVD_B,     4'd10, 32'shAAAA_5555, 1'b0);
    queue_cmd(CMD_PUSH_BACK,  4'd0,  32'sh5555_AAAA, 1'b0);
    queue_cmd(CMD_FIND,       4'd3,  32'sh5555_AAAA, 1'b0);

    for (int b = 0; b < RANDOM_BLOCKS; b++) begin
      mix = (b == 0) ? MIX_FILL : traffic_mix_e'($urandom_range(0, 3));
      for (int k = 0; k < BLOCK_ITEMS; k++) begin
        v = $urandom_range(0, 1) ? value_pool[$urandom_range(0, 7)] : $urandom;
        queue_cmd(pick_command(mix), POS_W'($urandom_range(0, 15)), v,
                  (k == 0) && (b == 0 || b == RANDOM_BLOCKS / 2));
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (pending_q.size() > 0 || in_valid_i || list_results_q.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (list_results_q.size() > 0) begin
      mismatches++;
      $display("%0d results never arrived", list_results_q.size());
    end
    if (mismatches == 0) begin
      $display("bounded_array_list_unit test passed");
    end else begin
      $display("bounded_array_list_unit test failed");
    end
    $finish;
  end

  initial begin
    #1_200_000;
    $display("bounded_array_list_unit test failed");
    $finish;
  end

endmodule
